### src/bracket_and_quote_balance_checker_unit_macros.svh
// Assertion macros for the bracket and quote balance checker.
// Included by the top level, which carries the concurrent checks; no other dependencies.
`ifndef BRACKET_AND_QUOTE_BALANCE_CHECKER_UNIT_MACROS_SVH
`define BRACKET_AND_QUOTE_BALANCE_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle
`define BQBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bqbc check failed");

// Antecedent implies consequent in the next cycle
`define BQBC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bqbc check failed");

// Condition never holds
`define BQBC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("bqbc check failed");

`else

`define BQBC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BQBC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`define BQBC_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### src/bqbc_pkg.sv
// Shared types, character codes and the character classifier of the checker.
// No dependencies; imported by the top level.
package bqbc_pkg;

  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned CodeW         = 3;

  typedef logic [CodeW-1:0] code_t;

  // Opener codes as kept on the stack
  localparam code_t CodeParen  = 3'd0;
  localparam code_t CodeBrack  = 3'd1;
  localparam code_t CodeBrace  = 3'd2;
  localparam code_t CodeAngle  = 3'd3;
  localparam code_t CodeSquote = 3'd4;
  localparam code_t CodeDquote = 3'd5;

  // Character values
  localparam logic [7:0] ChParenOpen  = 8'h28;
  localparam logic [7:0] ChParenClose = 8'h29;
  localparam logic [7:0] ChBrackOpen  = 8'h5B;
  localparam logic [7:0] ChBrackClose = 8'h5D;
  localparam logic [7:0] ChBraceOpen  = 8'h7B;
  localparam logic [7:0] ChBraceClose = 8'h7D;
  localparam logic [7:0] ChAngleOpen  = 8'h3C;
  localparam logic [7:0] ChAngleClose = 8'h3E;
  localparam logic [7:0] ChSquote     = 8'h27;
  localparam logic [7:0] ChDquote     = 8'h22;

  typedef enum logic [2:0] {
    KindNone,
    KindOpen,
    KindClose,
    KindSquote,
    KindDquote
  } kind_e;

  typedef struct packed {
    kind_e kind;
    code_t code;
  } char_class_t;

  // Map a raw byte to its role and stack code
  function automatic char_class_t classify(logic [7:0] ch);
    char_class_t c;
    c.kind = KindNone;
    c.code = CodeParen;
    unique case (ch)
      ChParenOpen:  begin c.kind = KindOpen;   c.code = CodeParen;  end
      ChBrackOpen:  begin c.kind = KindOpen;   c.code = CodeBrack;  end
      ChBraceOpen:  begin c.kind = KindOpen;   c.code = CodeBrace;  end
      ChAngleOpen:  begin c.kind = KindOpen;   c.code = CodeAngle;  end
      ChParenClose: begin c.kind = KindClose;  c.code = CodeParen;  end
      ChBrackClose: begin c.kind = KindClose;  c.code = CodeBrack;  end
      ChBraceClose: begin c.kind = KindClose;  c.code = CodeBrace;  end
      ChAngleClose: begin c.kind = KindClose;  c.code = CodeAngle;  end
      ChSquote:     begin c.kind = KindSquote; c.code = CodeSquote; end
      ChDquote:     begin c.kind = KindDquote; c.code = CodeDquote; end
      default:      begin c.kind = KindNone;   c.code = CodeParen;  end
    endcase
    return c;
  endfunction

endpackage

### src/bqbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the lower part of the opener stack.
module bqbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/bracket_and_quote_balance_checker_unit.sv
// Top level of the bracket and quote balance checker: stream ports, stack control, result word.
// Depends on bqbc_pkg, bqbc_ram and the assertion macro header.
//
// Checks a byte stream, one character per word, one word per clock cycle unless stalled. A
// string ends with the word that has tlast set; after that word passes the input register and
// the check stage, the result word is offered (bit 0 balanced, bit 1 stack overflow), and the
// next string may follow straight away. The stack top and the entry below it live in registers;
// the rest of the stack sits in a RAM with one write and one registered read port, which lets a
// push or pop complete every cycle the check stage advances. The RAM needs no clearing after
// reset. An input register and the result register flank the check logic, so a stalled result
// word holds back input only once the next string's last byte reaches the check stage.
`include "bracket_and_quote_balance_checker_unit_macros.svh"

module bracket_and_quote_balance_checker_unit
  import bqbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_byte
  input  logic       s_axis_tlast_i,   // last_char
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] valid_res, [1] stack_overflow, [7:2] zero
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  // Input register
  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Stack and string state
  logic [CntW-1:0] cnt_q, cnt_d;
  code_t           top_q, top_d;
  code_t           below_q, below_d;
  logic            sel_ram_q, sel_ram_d;
  logic            sq_q, sq_d;
  logic            dq_q, dq_d;
  logic            mis_q, mis_d;
  logic            ovf_q, ovf_d;

  // Result register
  logic out_vld_q;
  logic res_ok_q, res_ok_d;
  logic res_ovf_q, res_ovf_d;

  logic            proceed;
  logic            finish;
  char_class_t     cls;
  code_t           below;
  code_t           ram_rdata;
  logic            ram_we;
  logic            ram_re;
  logic            do_push;
  logic            do_pop;

  // Check stage advances unless it holds a last byte while a finished result is still waiting
  assign finish          = proceed & in_last_q;
  assign proceed         = in_vld_q & (~in_last_q | ~out_vld_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_vld_q | proceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Entry below the top: fresh RAM read after a pop, else the register copy
  assign below = sel_ram_q ? ram_rdata : below_q;

  // Push, pop and error tracking for one byte
  always_comb begin
    cls       = classify(in_char_q);
    cnt_d     = cnt_q;
    top_d     = top_q;
    below_d   = below;
    sel_ram_d = 1'b0;
    sq_d      = sq_q;
    dq_d      = dq_q;
    mis_d     = mis_q;
    ovf_d     = ovf_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;

    if (proceed && !mis_q && !ovf_q) begin
      unique case (cls.kind)
        KindOpen:  do_push = 1'b1;
        KindClose: do_pop  = 1'b1;
        KindSquote: begin
          sq_d    = ~sq_q;
          do_push = ~sq_q;
          do_pop  = sq_q;
        end
        KindDquote: begin
          dq_d    = ~dq_q;
          do_push = ~dq_q;
          do_pop  = dq_q;
        end
        default: ;
      endcase
    end

    if (do_push) begin
      if (cnt_q == CntW'(STACK_DEPTH)) begin
        ovf_d = 1'b1;
      end else begin
        ram_we  = (cnt_q != '0);
        top_d   = cls.code;
        below_d = top_q;
        cnt_d   = cnt_q + CntW'(1);
      end
    end

    if (do_pop) begin
      if (cnt_q == '0 || top_q != cls.code) begin
        mis_d = 1'b1;
      end else begin
        top_d     = below;
        cnt_d     = cnt_q - CntW'(1);
        ram_re    = 1'b1;
        sel_ram_d = 1'b1;
      end
    end

    res_ok_d  = ~mis_d & ~ovf_d & (cnt_d == '0);
    res_ovf_d = ovf_d;

    // Drop all string state after the last byte
    if (finish) begin
      cnt_d = '0;
      sq_d  = 1'b0;
      dq_d  = 1'b0;
      mis_d = 1'b0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      sel_ram_q <= 1'b0;
      sq_q      <= 1'b0;
      dq_q      <= 1'b0;
      mis_q     <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      sel_ram_q <= sel_ram_d;
      sq_q      <= sq_d;
      dq_q      <= dq_d;
      mis_q     <= mis_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    below_q <= below_d;
  end

  // Lower stack entries: old top written on push, next-below read on pop
  bqbc_ram #(
    .Width (CodeW),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(cnt_q - CntW'(1))),
    .wdata_i (top_q),
    .re_i    (ram_re),
    .raddr_i (AddrW'(cnt_q - CntW'(3))),
    .rdata_o (ram_rdata)
  );

  // Result word, held until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (finish) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_ok_q  <= res_ok_d;
      res_ovf_q <= res_ovf_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, res_ovf_q, res_ok_q};

  // Checks
  `BQBC_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CntW'(STACK_DEPTH))
  `BQBC_ASSERT_NXT(a_clear_after_last, clk_i, rst_ni, finish,
                   cnt_q == '0 && !mis_q && !ovf_q && !sq_q && !dq_q)
  `BQBC_ASSERT_NXT(a_result_after_last, clk_i, rst_ni, finish, m_axis_tvalid_o)
  `BQBC_ASSERT_NXT(a_freeze_on_error, clk_i, rst_ni, (mis_q || ovf_q) && !finish,
                   $stable(cnt_q) && $stable(sq_q) && $stable(dq_q))
  `BQBC_ASSERT_IMP(a_single_error, clk_i, rst_ni, mis_q, !ovf_q)

endmodule
